[src/qpgs_pkg.sv]
package qpgs_pkg;

    // Default image size limits.
    localparam int MAX_X_DEF = 256;
    localparam int MAX_Y_DEF = 256;
    localparam int MAX_Z_DEF = 1024;

    // Configuration port geometry.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 48;

    localparam logic [CFG_IW-1:0] REG_FACE    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_EDGE    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CORNER  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PENALTY = 3'd3;
    localparam logic [CFG_IW-1:0] REG_SIZE_X  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SIZE_Y  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_SIZE_Z  = 3'd6;

    localparam logic [47:0] FACE_RESET    = 48'd68720529408;
    localparam logic [15:0] PENALTY_RESET = 16'd256;
    localparam logic [8:0]  SIZE_XY_RESET = 9'd256;
    localparam logic [10:0] SIZE_Z_RESET  = 11'd1024;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push_wr;
        logic cen_rd;
        logic cen_lat;
        logic nb_rd;
        logic nb_step;
        logic mul1;
        logic mul2;
        logic acc;
        logic sc1;
        logic sc2;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic ready_push;
        logic ready_flush;
        logic nb_use;
        logic nb_last;
        logic out_free;
    } status_t;

endpackage

[src/qpgs_ram.sv]
module qpgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/qpgs_ctrl.sv]
module qpgs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tuser,
    output logic              s_tready,
    input  logic              cfg_we,
    input  qpgs_pkg::status_t status,
    output qpgs_pkg::cmd_t    cmd
);

    typedef enum logic [13:0] {
        ST_SETUP_A = 14'b00000000000001,
        ST_SETUP_B = 14'b00000000000010,
        ST_SETUP_C = 14'b00000000000100,
        ST_IDLE    = 14'b00000000001000,
        ST_DECIDE  = 14'b00000000010000,
        ST_CEN_RD  = 14'b00000000100000,
        ST_CEN_LAT = 14'b00000001000000,
        ST_NB      = 14'b00000010000000,
        ST_MUL1    = 14'b00000100000000,
        ST_MUL2    = 14'b00001000000000,
        ST_ACC     = 14'b00010000000000,
        ST_SC1     = 14'b00100000000000,
        ST_SC2     = 14'b01000000000000,
        ST_SC3     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;
    logic   ign_reg, ign_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        flush_next = flush_reg;
        ign_next   = ign_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_SETUP_A: state_next = ST_SETUP_B;
            ST_SETUP_B: state_next = ST_SETUP_C;
            ST_SETUP_C: state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    flush_next  = s_tuser;
                    ign_next    = !s_tuser && status.full;
                    cmd.push_wr = !s_tuser && !status.full;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (flush_reg ? status.ready_flush : (!ign_reg && status.ready_push)) begin
                    state_next = ST_CEN_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CEN_RD: begin
                cmd.cen_rd = 1'b1;
                state_next = ST_CEN_LAT;
            end
            ST_CEN_LAT: begin
                cmd.cen_lat = 1'b1;
                state_next  = ST_NB;
            end
            ST_NB: begin
                cmd.nb_rd = 1'b1;
                if (status.nb_use) begin
                    state_next = ST_MUL1;
                end else begin
                    cmd.nb_step = 1'b1;
                    state_next  = status.nb_last ? ST_SC1 : ST_NB;
                end
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc     = 1'b1;
                cmd.nb_step = 1'b1;
                state_next  = status.nb_last ? ST_SC1 : ST_NB;
            end
            ST_SC1: begin
                cmd.sc1    = 1'b1;
                state_next = ST_SC2;
            end
            ST_SC2: begin
                cmd.sc2    = 1'b1;
                state_next = ST_SC3;
            end
            ST_SC3: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_SETUP_A;
        endcase
        // A register write forces the derived sizes to settle again.
        if (cfg_we) begin
            state_next = ST_SETUP_A;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SETUP_A;
            flush_reg <= 1'b0;
            ign_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            ign_reg   <= ign_next;
        end
    end

endmodule

[src/qpgs_dp.sv]
module qpgs_dp #(
    parameter int MAX_X = qpgs_pkg::MAX_X_DEF,
    parameter int MAX_Y = qpgs_pkg::MAX_Y_DEF,
    parameter int MAX_Z = qpgs_pkg::MAX_Z_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [31:0]                   s_tdata,
    input  logic                          cfg_we,
    input  logic [qpgs_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [qpgs_pkg::CFG_DW-1:0]   cfg_data,
    input  qpgs_pkg::cmd_t                cmd,
    output qpgs_pkg::status_t             status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic                          m_tlast
);

    localparam int     RING = 2 * MAX_X * MAX_Y + 2 * MAX_X + 3;
    localparam int     AW   = $clog2(RING);
    localparam int     OW   = AW + 2;
    localparam int     XW   = $clog2(MAX_X + 1);
    localparam int     YW   = $clog2(MAX_Y + 1);
    localparam int     ZW   = $clog2(MAX_Z + 1);
    localparam int     SLW  = $clog2(MAX_X * MAX_Y + 1);
    localparam longint PMAX = longint'(MAX_X) * MAX_Y * MAX_Z + MAX_X + 1;
    localparam int     PW   = $clog2(PMAX + 1);
    localparam int     PRW  = SLW + ZW;
    localparam int     SUMW = 58;
    localparam int     S16W = SUMW - 18;
    localparam int     PRDW = S16W + 17;
    localparam int     GW   = PRDW - 16;

    // Configuration registers.
    logic [47:0] face_reg, edge_reg;
    logic [15:0] corner_reg, pen_reg;
    logic [8:0]  size_x_reg, size_y_reg;
    logic [10:0] size_z_reg;
    logic        size_wr;

    assign size_wr = cfg_we && (cfg_index == qpgs_pkg::REG_SIZE_X ||
                                cfg_index == qpgs_pkg::REG_SIZE_Y ||
                                cfg_index == qpgs_pkg::REG_SIZE_Z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_reg   <= qpgs_pkg::FACE_RESET;
            edge_reg   <= '0;
            corner_reg <= '0;
            pen_reg    <= qpgs_pkg::PENALTY_RESET;
            size_x_reg <= qpgs_pkg::SIZE_XY_RESET;
            size_y_reg <= qpgs_pkg::SIZE_XY_RESET;
            size_z_reg <= qpgs_pkg::SIZE_Z_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                qpgs_pkg::REG_FACE:    face_reg   <= cfg_data;
                qpgs_pkg::REG_EDGE:    edge_reg   <= cfg_data;
                qpgs_pkg::REG_CORNER:  corner_reg <= cfg_data[15:0];
                qpgs_pkg::REG_PENALTY: pen_reg    <= cfg_data[15:0];
                qpgs_pkg::REG_SIZE_X:  size_x_reg <= cfg_data[8:0];
                qpgs_pkg::REG_SIZE_Y:  size_y_reg <= cfg_data[8:0];
                qpgs_pkg::REG_SIZE_Z:  size_z_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Clamped sizes, then the slice size, then the total count and the reach, each registered.
    logic [31:0]    sx_w, sy_w, sz_w;
    logic [XW-1:0]  sx_reg;
    logic [YW-1:0]  sy_reg;
    logic [ZW-1:0]  sz_reg;
    logic [SLW-1:0] sl_reg;
    logic [PW-1:0]  total_reg, reach_reg;

    always_comb begin
        sx_w = (size_x_reg == '0) ? 32'd1 :
               ((32'(size_x_reg) > 32'(MAX_X)) ? 32'(MAX_X) : 32'(size_x_reg));
        sy_w = (size_y_reg == '0) ? 32'd1 :
               ((32'(size_y_reg) > 32'(MAX_Y)) ? 32'(MAX_Y) : 32'(size_y_reg));
        sz_w = (size_z_reg == '0) ? 32'd1 :
               ((32'(size_z_reg) > 32'(MAX_Z)) ? 32'(MAX_Z) : 32'(size_z_reg));
    end

    always_ff @(posedge aclk) begin
        sx_reg    <= XW'(sx_w);
        sy_reg    <= YW'(sy_w);
        sz_reg    <= ZW'(sz_w);
        sl_reg    <= SLW'(32'(sx_reg) * 32'(sy_reg));
        total_reg <= PW'(PRW'(sl_reg) * PRW'(sz_reg));
        reach_reg <= PW'(sl_reg) + PW'(sx_reg) + PW'(1);
    end

    // Stream positions, ring addresses and the coordinates of the next result.
    logic [PW-1:0] in_pos_reg, out_pos_reg;
    logic [AW-1:0] in_addr_reg, out_addr_reg;
    logic [XW-1:0] ox_reg;
    logic [YW-1:0] oy_reg;
    logic [ZW-1:0] oz_reg;
    logic          vol_end;

    assign vol_end = cmd.emit && (out_pos_reg + PW'(1) == total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || size_wr || vol_end) begin
            in_pos_reg   <= '0;
            out_pos_reg  <= '0;
            in_addr_reg  <= '0;
            out_addr_reg <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            oz_reg       <= '0;
        end else begin
            if (cmd.push_wr) begin
                in_pos_reg  <= in_pos_reg + PW'(1);
                in_addr_reg <= (in_addr_reg == AW'(RING - 1)) ? '0 : in_addr_reg + AW'(1);
            end
            if (cmd.emit) begin
                out_pos_reg  <= out_pos_reg + PW'(1);
                out_addr_reg <= (out_addr_reg == AW'(RING - 1)) ? '0 : out_addr_reg + AW'(1);
                if (ox_reg == sx_reg - XW'(1)) begin
                    ox_reg <= '0;
                    if (oy_reg == sy_reg - YW'(1)) begin
                        oy_reg <= '0;
                        oz_reg <= oz_reg + ZW'(1);
                    end else begin
                        oy_reg <= oy_reg + YW'(1);
                    end
                end else begin
                    ox_reg <= ox_reg + XW'(1);
                end
            end
        end
    end

    // Neighbour walk: each index runs 0..2 for an offset of -1..+1.
    logic [1:0] nbx_reg, nby_reg, nbz_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cen_rd) begin
            nbx_reg <= '0;
            nby_reg <= '0;
            nbz_reg <= '0;
        end else if (cmd.nb_step) begin
            if (nbx_reg == 2'd2) begin
                nbx_reg <= '0;
                if (nby_reg == 2'd2) begin
                    nby_reg <= '0;
                    nbz_reg <= nbz_reg + 2'd1;
                end else begin
                    nby_reg <= nby_reg + 2'd1;
                end
            end else begin
                nbx_reg <= nbx_reg + 2'd1;
            end
        end
    end

    logic                 fx, fy, fz, inx, iny, inz;
    logic [15:0]          w_sel;
    logic signed [OW-1:0] off, addr_s;
    logic [AW-1:0]        nb_addr;

    always_comb begin
        fx = (nbx_reg != 2'd1);
        fy = (nby_reg != 2'd1);
        fz = (nbz_reg != 2'd1);
        inx = (nbx_reg == 2'd0) ? (ox_reg != '0) :
              (nbx_reg == 2'd2) ? (ox_reg != sx_reg - XW'(1)) : 1'b1;
        iny = (nby_reg == 2'd0) ? (oy_reg != '0) :
              (nby_reg == 2'd2) ? (oy_reg != sy_reg - YW'(1)) : 1'b1;
        inz = (nbz_reg == 2'd0) ? (oz_reg != '0) :
              (nbz_reg == 2'd2) ? (oz_reg != sz_reg - ZW'(1)) : 1'b1;
        unique case ({fz, fy, fx})
            3'b001:  w_sel = face_reg[15:0];
            3'b010:  w_sel = face_reg[31:16];
            3'b100:  w_sel = face_reg[47:32];
            3'b011:  w_sel = edge_reg[15:0];
            3'b101:  w_sel = edge_reg[31:16];
            3'b110:  w_sel = edge_reg[47:32];
            3'b111:  w_sel = corner_reg;
            default: w_sel = '0;
        endcase
        off = '0;
        unique case (nbx_reg)
            2'd0:    off = off - OW'(1);
            2'd2:    off = off + OW'(1);
            default: ;
        endcase
        unique case (nby_reg)
            2'd0:    off = off - $signed(OW'(sx_reg));
            2'd2:    off = off + $signed(OW'(sx_reg));
            default: ;
        endcase
        unique case (nbz_reg)
            2'd0:    off = off - $signed(OW'(sl_reg));
            2'd2:    off = off + $signed(OW'(sl_reg));
            default: ;
        endcase
        addr_s = $signed(OW'(out_addr_reg)) + off;
        if (addr_s < 0) begin
            addr_s = addr_s + $signed(OW'(RING));
        end else if (addr_s >= $signed(OW'(RING))) begin
            addr_s = addr_s - $signed(OW'(RING));
        end
        nb_addr = addr_s[AW-1:0];
    end

    // Window store.
    logic [31:0] rdata;

    qpgs_ram #(
        .WIDTH (32),
        .DEPTH (RING)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.push_wr),
        .waddr (in_addr_reg),
        .wdata (s_tdata),
        .re    (cmd.cen_rd || cmd.nb_rd),
        .raddr (cmd.cen_rd ? out_addr_reg : nb_addr),
        .rdata (rdata)
    );

    // Arithmetic.
    logic [15:0]            vc_reg, kc_reg, w_reg;
    logic [31:0]            kkp_reg;
    logic signed [33:0]     wd_reg;
    logic signed [52:0]     term_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [S16W-1:0] s16_reg;
    logic signed [PRDW-1:0] prod_reg;
    logic signed [16:0]     diff;
    logic [31:0]            kk_rnd;
    logic signed [PRDW-1:0] prod_rnd;
    logic signed [GW-1:0]   g;
    logic [31:0]            g_sat;
    logic signed [SUMW-1:0] sum_rnd;

    always_comb begin
        diff     = $signed({1'b0, vc_reg}) - $signed({1'b0, rdata[15:0]});
        kk_rnd   = kkp_reg + 32'd8192;
        sum_rnd  = sum_reg + $signed(SUMW'(1) << 17);
        prod_rnd = prod_reg + $signed(PRDW'(1) << 15);
        g        = prod_rnd[PRDW-1:16];
        if (g > $signed(GW'(32'h7FFF_FFFF))) begin
            g_sat = 32'h7FFF_FFFF;
        end else if (g < -$signed(GW'(33'h1_0000_0000) >>> 1)) begin
            g_sat = 32'h8000_0000;
        end else begin
            g_sat = g[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cen_lat) begin
            vc_reg <= rdata[15:0];
            kc_reg <= rdata[31:16];
        end
        if (cmd.nb_rd) begin
            w_reg <= w_sel;
        end
        if (cmd.mul1) begin
            kkp_reg <= kc_reg * rdata[31:16];
            wd_reg  <= $signed({1'b0, w_reg}) * diff;
        end
        if (cmd.mul2) begin
            term_reg <= wd_reg * $signed({1'b0, kk_rnd[31:14]});
        end
        if (cmd.cen_rd) begin
            sum_reg <= '0;
        end else if (cmd.acc) begin
            sum_reg <= sum_reg + SUMW'(term_reg);
        end
        if (cmd.sc1) begin
            s16_reg <= sum_rnd[SUMW-1:18];
        end
        if (cmd.sc2) begin
            prod_reg <= s16_reg * $signed({1'b0, pen_reg});
        end
    end

    // Output register.
    logic        out_valid_reg, out_last_reg;
    logic [31:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= g_sat;
            out_last_reg <= (out_pos_reg + PW'(1) == total_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        status.full        = (in_pos_reg == total_reg);
        status.ready_push  = (out_pos_reg < in_pos_reg) &&
                             ((in_pos_reg == total_reg) ||
                              (in_pos_reg - out_pos_reg > reach_reg));
        status.ready_flush = (in_pos_reg == total_reg) && (out_pos_reg < total_reg);
        status.nb_use      = inx && iny && inz && (fx || fy || fz) && (w_sel != '0);
        status.nb_last     = (nbx_reg == 2'd2) && (nby_reg == 2'd2) && (nbz_reg == 2'd2);
        status.out_free    = !out_valid_reg || m_tready;
    end

endmodule

[src/quadratic_prior_gradient_stencil.sv]
// Quadratic smoothness prior gradient over a 3x3x3 neighbourhood. Voxels of one volume
// enter in raster order (x fastest) on the s_ channel, each with its Q8.8 value and its
// Q2.14 kappa, and are kept in a ring store of 2*MAX_X*MAX_Y + 2*MAX_X + 3 entries.
// A result on the m_ channel is the Q24.8 gradient of one voxel, saturated, and follows
// once every neighbour of that voxel has arrived; tlast marks the final voxel of the
// volume. When all voxels are in, flush transfers (tuser high) drain the remaining
// results one per transfer. One input transfer is handled at a time. A transfer that
// gives no result goes back to idle. A transfer that gives a result reads the centre
// voxel, then the neighbours in turn, skipping those that do not contribute, and then
// scales the sum: the neighbours are read one by one through the single read port of
// the ring store and go through one shared multiply chain. A finished result waits in
// an output register, so the next input transfer is accepted while it is held. After
// reset and after every register write the block passes through its setup states to
// settle its derived sizes before it accepts input. Writing a size register starts a
// new volume; weights and penalty apply to results formed after the write.
module quadratic_prior_gradient_stencil #(
    parameter int MAX_X = qpgs_pkg::MAX_X_DEF,
    parameter int MAX_Y = qpgs_pkg::MAX_Y_DEF,
    parameter int MAX_Z = qpgs_pkg::MAX_Z_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input channel.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // voxel_value [15:0], voxel_kappa [31:16]
    input  logic                        s_tuser,   // action: 0 push, 1 flush
    // Result channel.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // gradient [31:0]
    output logic                        m_tlast,
    // Configuration write port.
    input  logic                        cfg_we,
    input  logic [qpgs_pkg::CFG_IW-1:0] cfg_index,
    input  logic [qpgs_pkg::CFG_DW-1:0] cfg_data
);

    qpgs_pkg::cmd_t    cmd;
    qpgs_pkg::status_t status;

    // The controller sequences one transfer through the datapath.
    qpgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cfg_we   (cfg_we),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the ring store and the arithmetic.
    qpgs_dp #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
